FILE: rtl/tbpq_pkg.sv
// ----------------------------------------------------------------------------
// tbpq_pkg: shared constants for the three-band priority queue
// Operation and status codes, register indexes, field widths, reset values.
// ----------------------------------------------------------------------------
package tbpq_pkg;

  localparam int NUM_BANDS       = 3;
  localparam int BAND_DEPTH_DEF  = 1024;
  localparam int HANDLE_BITS_DEF = 16;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int PRIO_W   = 8;
  localparam int HNDL_W   = 16;
  localparam int KEY_W    = 2;
  localparam int STAT_W   = 3;
  localparam int BAND_W   = 2;
  localparam int TOT_W    = 11;
  localparam int MAP_W    = 32;
  localparam int MAP_IDX_W = 4;
  localparam int CFG_W    = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // key buffer status
  localparam logic [KEY_W-1:0] KEY_EMPTY = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 3'd2;
  localparam logic [STAT_W-1:0] ST_PEEKED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

  // band numbers
  localparam logic [BAND_W-1:0] BAND_0 = 2'd0;
  localparam logic [BAND_W-1:0] BAND_1 = 2'd1;
  localparam logic [BAND_W-1:0] BAND_2 = 2'd2;
  localparam logic [BAND_W-1:0] BAND_3 = 2'd3;

  // configuration register indexes
  localparam logic REG_MAX_PACKETS  = 1'b0;
  localparam logic REG_PRIORITY_MAP = 1'b1;

  // register reset values
  localparam logic [TOT_W-1:0] MAX_PACKETS_RST  = 11'd1000;
  localparam logic [MAP_W-1:0] PRIORITY_MAP_RST = 32'h5555_09A9;

endpackage

FILE: rtl/three_band_priority_queue_gated.sv
// ----------------------------------------------------------------------------
// three_band_priority_queue_gated: three-band strict-priority handle queue
// Enqueue, dequeue and peek requests against three circular FIFOs kept in
// one shared RAM, with a total packet limit and key-buffer gating.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries kind, priority tag,
//   handle and key-buffer status. Result channel (out_valid_o / out_stall_i)
//   returns exactly one result per request, in request order.
//   Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 max_packets, 1 priority_map); write only while no request is in flight.
// Pipeline and throughput:
//   A request is registered, then decided: band pointers and counts update
//   and the single RAM port is read or written. The result register loads
//   when the decide stage fires, together with the RAM read data, and
//   out_valid_o rises with it. One request is accepted every cycle while
//   out_stall_i does not hold a valid result; the single RAM port and the
//   pointer update set that figure.
// Reset:
//   All bands empty, total zero, registers at their reset values. RAM
//   contents are not cleared; empty slots are never read.
// Stall:
//   While out_stall_i holds a valid result, the decide stage holds, no RAM
//   read is issued (so read data holds) and in_stall_o rises once the
//   request register is full.
// ----------------------------------------------------------------------------
module three_band_priority_queue_gated #(
  parameter int BAND_DEPTH  = tbpq_pkg::BAND_DEPTH_DEF,
  parameter int HANDLE_BITS = tbpq_pkg::HANDLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tbpq_pkg::CFG_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tbpq_pkg::KIND_W-1:0]  kind_i,
  input  logic [tbpq_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic [tbpq_pkg::HNDL_W-1:0]  item_handle_i,
  input  logic [tbpq_pkg::KEY_W-1:0]   key_status_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tbpq_pkg::STAT_W-1:0]  status_o,
  output logic [tbpq_pkg::HNDL_W-1:0]  out_handle_o,
  output logic [tbpq_pkg::BAND_W-1:0]  out_band_o,
  output logic [tbpq_pkg::TOT_W-1:0]   total_count_o
);

  import tbpq_pkg::*;

  localparam int PTR_W  = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BAND_DEPTH + 1);
  localparam int DEPTH  = NUM_BANDS * BAND_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BAND_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BAND_DEPTH);
  localparam logic [ADDR_W-1:0] BASE_1    = ADDR_W'(BAND_DEPTH);
  localparam logic [ADDR_W-1:0] BASE_2    = ADDR_W'(2 * BAND_DEPTH);

  // configuration registers
  logic [TOT_W-1:0] max_packets_q;
  logic [MAP_W-1:0] priority_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packets_q  <= MAX_PACKETS_RST;
      priority_map_q <= PRIORITY_MAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_PACKETS:  max_packets_q  <= cfg_wdata_i[TOT_W-1:0];
        REG_PRIORITY_MAP: priority_map_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q;
  logic advance, in_accept, fire;

  assign advance   = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;
  assign fire      = s1_valid_q && advance;

  // request register (payload needs no reset)
  logic [KIND_W-1:0]      kind_q;
  logic [MAP_IDX_W-1:0]   prio_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [KEY_W-1:0]       key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= kind_i;
      prio_q   <= priority_req_i[MAP_IDX_W-1:0];
      handle_q <= HANDLE_BITS'(item_handle_i);
      key_q    <= key_status_i;
    end
  end

  // queue state
  logic [PTR_W-1:0] head_q  [NUM_BANDS];
  logic [PTR_W-1:0] tail_q  [NUM_BANDS];
  logic [CNT_W-1:0] count_q [NUM_BANDS];
  logic [TOT_W-1:0] total_q;

  logic [PTR_W-1:0] head_d  [NUM_BANDS];
  logic [PTR_W-1:0] tail_d  [NUM_BANDS];
  logic [CNT_W-1:0] count_d [NUM_BANDS];
  logic [TOT_W-1:0] total_d;

  // decide stage
  logic [BAND_W-1:0] map_raw, enq_band, srv_band, sel_band;
  logic              srv_found, gated;
  logic [STAT_W-1:0] res_status;
  logic [BAND_W-1:0] res_band;
  logic              res_rd;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  sel_ptr;
  logic [ADDR_W-1:0] band_base, ram_addr;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    // map lookup; map value three folds into band 2
    map_raw  = priority_map_q[{prio_q, 1'b0} +: BAND_W];
    enq_band = (map_raw == BAND_3) ? BAND_2 : map_raw;

    // serve the lowest non-empty band; an empty key buffer gates dequeue from bands 1 and 2
    gated = (kind_q == KIND_DEQ) && (key_q == KEY_EMPTY);
    priority if (count_q[0] != '0) begin
      srv_found = 1'b1;
      srv_band  = BAND_0;
    end else if (gated) begin
      srv_found = 1'b0;
      srv_band  = BAND_0;
    end else if (count_q[1] != '0) begin
      srv_found = 1'b1;
      srv_band  = BAND_1;
    end else if (count_q[2] != '0) begin
      srv_found = 1'b1;
      srv_band  = BAND_2;
    end else begin
      srv_found = 1'b0;
      srv_band  = BAND_0;
    end

    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    total_d = total_q;
    res_status = ST_NONE;
    res_band   = BAND_0;
    res_rd     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    sel_band   = srv_band;
    sel_ptr    = head_q[srv_band];

    unique case (kind_q)
      KIND_ENQ: begin
        sel_band = enq_band;
        sel_ptr  = tail_q[enq_band];
        res_band = enq_band;
        if (total_q >= max_packets_q || count_q[enq_band] == CNT_FULL) begin
          res_status = ST_DROPPED;
        end else begin
          res_status        = ST_ENQUEUED;
          ram_we            = fire;
          tail_d[enq_band]  = next_slot(tail_q[enq_band]);
          count_d[enq_band] = count_q[enq_band] + CNT_W'(1);
          total_d           = total_q + TOT_W'(1);
        end
      end
      KIND_DEQ: begin
        if (srv_found) begin
          res_status        = ST_DEQUEUED;
          res_band          = srv_band;
          res_rd            = 1'b1;
          ram_re            = fire;
          head_d[srv_band]  = next_slot(head_q[srv_band]);
          count_d[srv_band] = count_q[srv_band] - CNT_W'(1);
          total_d           = total_q - TOT_W'(1);
        end
      end
      KIND_PEEK: begin
        if (srv_found) begin
          res_status = ST_PEEKED;
          res_band   = srv_band;
          res_rd     = 1'b1;
          ram_re     = fire;
        end
      end
      default: ;
    endcase

    unique case (sel_band)
      BAND_0:  band_base = '0;
      BAND_1:  band_base = BASE_1;
      default: band_base = BASE_2;
    endcase
    ram_addr = band_base + ADDR_W'(sel_ptr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        head_q[b]  <= '0;
        tail_q[b]  <= '0;
        count_q[b] <= '0;
      end
      total_q <= '0;
    end else if (fire) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // band storage
  logic [HANDLE_BITS-1:0] ram_rdata;

  tbpq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (handle_q),
    .rdata_o (ram_rdata)
  );

  // result register; handle comes straight from the RAM read register
  logic [STAT_W-1:0] res_status_q;
  logic [BAND_W-1:0] res_band_q;
  logic [TOT_W-1:0]  res_total_q;
  logic              res_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= res_status;
      res_band_q   <= res_band;
      res_total_q  <= total_d;
      res_rd_q     <= res_rd;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign status_o      = res_status_q;
  assign out_band_o    = res_band_q;
  assign total_count_o = res_total_q;
  assign out_handle_o  = res_rd_q ? HNDL_W'(ram_rdata) : '0;

endmodule

FILE: rtl/tbpq_ram.sv
// ----------------------------------------------------------------------------
// tbpq_ram: generic single-port RAM
// One write or one read per cycle; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module tbpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
